// ----- sv/lruc_pkg.sv -----
// Shared types and constants of the LRU cache hit counter.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lruc_pkg;

    localparam int LINE_SHIFT_W = 5;
    localparam int COUNT_W      = 32;

    localparam logic [LINE_SHIFT_W-1:0] LINE_SHIFT_RESET = 5'd7;

    typedef enum logic
    {
        REQ_ACCESS = 1'b0,
        REQ_CLEAR  = 1'b1
    } req_type_t;

    typedef struct packed
    {
        logic init_wr;
        logic load;
        logic scan_rd;
        logic commit;
    } lruc_cmd_t;

    typedef struct packed
    {
        logic idx_last;
        logic out_free;
    } lruc_sts_t;

endpackage

// ----- sv/lruc_if.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on lruc_pkg for the counter width.
`timescale 1ns / 1ps

interface lruc_req_if #(parameter int ADDR_BITS = 31);
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [ADDR_BITS-1:0] addr;

    modport source (output valid, output req_type, output addr, input ready);
    modport sink   (input valid, input req_type, input addr, output ready);
endinterface

interface lruc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [lruc_pkg::COUNT_W-1:0]  hit_total;
    logic [lruc_pkg::COUNT_W-1:0]  miss_total;

    modport source (output valid, output hit, output hit_total, output miss_total,
                    input ready);
    modport sink   (input valid, input hit, input hit_total, input miss_total,
                    output ready);
endinterface

// ----- sv/lruc_ctrl.sv -----
// Sequencer of the LRU cache hit counter: clearing pass, accept, scan and commit.
// Depends on lruc_pkg for the command and status structs.
`timescale 1ns / 1ps

module lruc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_type,
    input  lruc_pkg::lruc_sts_t sts,
    output lruc_pkg::lruc_cmd_t cmd,
    output logic                req_ready
);
    import lruc_pkg::*;

    typedef enum logic [2:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
                if (req_valid)
                begin
                    state_next = (req_type == REQ_CLEAR) ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/lruc_dp.sv -----
// Datapath of the LRU cache hit counter: line memory, scan pipeline, counters, result.
// Depends on lruc_pkg; driven by lruc_ctrl through the command and status structs.
`timescale 1ns / 1ps

module lruc_dp #(
    parameter int NUM_LINES = 512,
    parameter int ADDR_BITS = 31
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lruc_pkg::lruc_cmd_t                  cmd,
    output lruc_pkg::lruc_sts_t                  sts,
    input  logic                                 cfg_wr_en,
    input  logic [lruc_pkg::LINE_SHIFT_W-1:0]    cfg_wr_data,
    input  logic                                 req_type,
    input  logic [ADDR_BITS-1:0]                 req_addr,
    input  logic                                 rsp_ready,
    output logic                                 rsp_valid,
    output logic                                 rsp_hit,
    output logic [lruc_pkg::COUNT_W-1:0]         rsp_hit_total,
    output logic [lruc_pkg::COUNT_W-1:0]         rsp_miss_total
);
    import lruc_pkg::*;

    localparam int IDX_W = $clog2(NUM_LINES);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [ADDR_BITS-1:0] tag_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef struct packed
    {
        logic valid;
        idx_t rank;
        tag_t tag;
    } entry_t;

    localparam idx_t LAST_IDX = idx_t'(NUM_LINES - 1);

    entry_t mem [NUM_LINES];

    entry_t                    rd_data_reg;
    entry_t                    upd_entry;
    idx_t                      idx_reg;
    idx_t                      ev_addr_reg;
    logic                      ev_valid_reg;
    tag_t                      line_no_reg;
    logic                      req_clear_reg;
    logic                      found_reg;
    idx_t                      used_slot_reg;
    idx_t                      used_rank_reg;
    idx_t                      victim_reg;
    logic                      pend_valid_reg;
    logic                      pend_miss_reg;
    idx_t                      pend_slot_reg;
    idx_t                      pend_rank_reg;
    tag_t                      pend_tag_reg;
    logic [LINE_SHIFT_W-1:0]   line_shift_reg;
    count_t                    hit_count_reg;
    count_t                    hit_count_next;
    count_t                    miss_count_reg;
    count_t                    miss_count_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    logic                      ev_match;
    logic                      ev_victim;

    // The previous access's rank update is applied as each line passes by.
    always_comb
    begin
        upd_entry = rd_data_reg;
        if (pend_valid_reg && (ev_addr_reg == pend_slot_reg))
        begin
            upd_entry.rank = '0;
            if (pend_miss_reg)
            begin
                upd_entry.valid = 1'b1;
                upd_entry.tag   = pend_tag_reg;
            end
        end
        else if (pend_valid_reg && (rd_data_reg.rank < pend_rank_reg))
        begin
            upd_entry.rank = rd_data_reg.rank + 1'b1;
        end
        ev_match  = upd_entry.valid && (upd_entry.tag == line_no_reg);
        ev_victim = (upd_entry.rank == LAST_IDX);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
        begin
            mem[idx_reg] <= '{valid: 1'b0, rank: idx_reg, tag: '0};
        end
        else if (ev_valid_reg)
        begin
            mem[ev_addr_reg] <= upd_entry;
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        ev_addr_reg <= idx_reg;
        if (cmd.load)
        begin
            line_no_reg   <= req_addr >> line_shift_reg;
            req_clear_reg <= (req_type == REQ_CLEAR);
        end
        if (ev_valid_reg && ev_match && !found_reg)
        begin
            used_slot_reg <= ev_addr_reg;
            used_rank_reg <= upd_entry.rank;
        end
        if (ev_valid_reg && ev_victim)
        begin
            victim_reg <= ev_addr_reg;
        end
        if (cmd.commit && !req_clear_reg)
        begin
            pend_miss_reg <= !found_reg;
            pend_slot_reg <= found_reg ? used_slot_reg : victim_reg;
            pend_rank_reg <= found_reg ? used_rank_reg : LAST_IDX;
            pend_tag_reg  <= line_no_reg;
        end
    end

    always_comb
    begin
        hit_count_next  = hit_count_reg;
        miss_count_next = miss_count_reg;
        hit_next        = hit_reg;
        if (cmd.commit)
        begin
            if (req_clear_reg)
            begin
                hit_count_next  = '0;
                miss_count_next = '0;
                hit_next        = 1'b0;
            end
            else if (found_reg)
            begin
                hit_count_next = (hit_count_reg == '1) ? hit_count_reg : hit_count_reg + 1'b1;
                hit_next       = 1'b1;
            end
            else
            begin
                miss_count_next = (miss_count_reg == '1) ? miss_count_reg
                                                         : miss_count_reg + 1'b1;
                hit_next        = 1'b0;
            end
        end
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            ev_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            line_shift_reg <= LINE_SHIFT_RESET;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            hit_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            ev_valid_reg   <= cmd.scan_rd;
            hit_count_reg  <= hit_count_next;
            miss_count_reg <= miss_count_next;
            hit_reg        <= hit_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                line_shift_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.init_wr || cmd.scan_rd)
            begin
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (ev_valid_reg && ev_match)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit && !req_clear_reg)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    assign sts.idx_last    = (idx_reg == LAST_IDX);
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp_hit         = hit_reg;
    assign rsp_hit_total   = hit_count_reg;
    assign rsp_miss_total  = miss_count_reg;

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid_reg || rsp_ready))
        else $error("Result committed while the previous beat is still held.");

    a_single_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.init_wr && cmd.scan_rd))
        else $error("Clearing pass and scan drive the memory together.");

    a_miss_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !req_clear_reg && !found_reg) |=>
            (pend_miss_reg && (pend_rank_reg == LAST_IDX)))
        else $error("Miss did not schedule the least recent line for refill.");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && hit_reg) |-> (hit_count_reg != '0))
        else $error("Hit reported with a zero hit total.");
`endif

endmodule

// ----- sv/lru_cache_hit_counter_unit.sv -----
// Top level of the LRU cache hit counter: a fully associative cache model with
// true LRU replacement that counts hits and misses. Depends on lruc_pkg, lruc_if,
// lruc_ctrl and lruc_dp.
`timescale 1ns / 1ps

// After reset the block clears its line memory with req.ready low; configuration
// writes are taken during that time. For an access beat, every line's tag and
// recency rank is read from the single line memory once, one line per cycle,
// before its result beat, and the rank update of each access is written back
// during the scan of the next one. A clear beat skips the scan. The result
// sits in an output register, so the next request is accepted while a result
// is still held.
module lru_cache_hit_counter_unit #(
    parameter int NUM_LINES = 512,
    parameter int ADDR_BITS = 31
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    lruc_req_if.sink                          req,
    lruc_rsp_if.source                        rsp,
    input  logic                              cfg_wr_en,
    input  logic [lruc_pkg::LINE_SHIFT_W-1:0] cfg_wr_data
);
    import lruc_pkg::*;

    lruc_cmd_t cmd;
    lruc_sts_t sts;
    logic      req_ready;

    lruc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .sts       (sts),
        .cmd       (cmd),
        .req_ready (req_ready)
    );

    lruc_dp #(
        .NUM_LINES (NUM_LINES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_type       (req.req_type),
        .req_addr       (req.addr),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_hit        (rsp.hit),
        .rsp_hit_total  (rsp.hit_total),
        .rsp_miss_total (rsp.miss_total)
    );

    assign req.ready = req_ready;

endmodule

// ----- tb/lru_cache_hit_counter_unit_tb.sv -----
// Self-checking testbench for lru_cache_hit_counter_unit: drives access and clear beats,
// predicts hit flags and saturating hit/miss totals with its own LRU cache model.
// Depends on lruc_pkg, lruc_if and the RTL of the unit.
`timescale 1ns / 1ps

module lru_cache_hit_counter_unit_tb;
    import lruc_pkg::*;

    localparam int NUM_LINES   = 512;
    localparam int ADDR_BITS   = 31;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HISTORY_MAX = 800;

    typedef struct packed
    {
        req_type_t            kind;
        logic [ADDR_BITS-1:0] addr;
    } cache_req_t;

    typedef struct packed
    {
        logic               hit;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
    } tally_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LINE_SHIFT_W-1:0] cfg_wr_data;

    lruc_req_if #(.ADDR_BITS(ADDR_BITS)) req_if();
    lruc_rsp_if rsp_if();

    lru_cache_hit_counter_unit #(
        .NUM_LINES(NUM_LINES),
        .ADDR_BITS(ADDR_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    cache_req_t access_q[$];
    tally_t tally_q[$];
    logic [ADDR_BITS-1:0] addr_history[$];

    logic [ADDR_BITS-1:0] model_tag[NUM_LINES];
    bit model_valid[NUM_LINES];
    int unsigned model_rank[NUM_LINES];
    logic [COUNT_W-1:0] hit_tally;
    logic [COUNT_W-1:0] miss_tally;
    logic [LINE_SHIFT_W-1:0] shift_shadow;

    int src_idle_pct;
    int snk_stall_pct;
    int error_count;
    int cycle_count;

    function automatic tally_t apply_access(req_type_t kind, logic [ADDR_BITS-1:0] addr);
        tally_t t;
        logic [ADDR_BITS-1:0] line_no;
        bit found;
        int slot;
        int unsigned used_rank;
        t = '0;
        if (kind == REQ_CLEAR)
        begin
            hit_tally = '0;
            miss_tally = '0;
            return t;
        end
        line_no = addr >> shift_shadow;
        found = 0;
        slot = 0;
        for (int k = 0; k < NUM_LINES; k++)
        begin
            if (!found && model_valid[k] && model_tag[k] == line_no)
            begin
                slot = k;
                found = 1;
            end
        end
        if (!found)
        begin
            for (int k = 0; k < NUM_LINES; k++)
            begin
                if (model_rank[k] == NUM_LINES - 1)
                    slot = k;
            end
            model_tag[slot] = line_no;
            model_valid[slot] = 1;
            if (miss_tally != '1)
                miss_tally = miss_tally + 1;
        end
        else if (hit_tally != '1)
        begin
            hit_tally = hit_tally + 1;
        end
        used_rank = model_rank[slot];
        for (int k = 0; k < NUM_LINES; k++)
        begin
            if (model_rank[k] < used_rank)
                model_rank[k] = model_rank[k] + 1;
        end
        model_rank[slot] = 0;
        t.hit = found;
        t.hit_total = hit_tally;
        t.miss_total = miss_tally;
        return t;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        cache_req_t item;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                tally_q.push_back(apply_access(req_type_t'(req_if.req_type), req_if.addr));
            if (!(req_if.valid && !req_if.ready))
            begin
                if (access_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    item = access_q.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.req_type <= item.kind;
                    req_if.addr <= item.addr;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        tally_t exp_t;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (tally_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result beat with none expected: hit=%0d hits=%0d misses=%0d",
                             $realtime, rsp_if.hit, rsp_if.hit_total, rsp_if.miss_total);
                end
                else
                begin
                    exp_t = tally_q.pop_front();
                    if (rsp_if.hit !== exp_t.hit)
                    begin
                        error_count++;
                        $display("%0t: hit expected %0d actual %0d",
                                 $realtime, exp_t.hit, rsp_if.hit);
                    end
                    if (rsp_if.hit_total !== exp_t.hit_total)
                    begin
                        error_count++;
                        $display("%0t: hit_total expected %0d actual %0d",
                                 $realtime, exp_t.hit_total, rsp_if.hit_total);
                    end
                    if (rsp_if.miss_total !== exp_t.miss_total)
                    begin
                        error_count++;
                        $display("%0t: miss_total expected %0d actual %0d",
                                 $realtime, exp_t.miss_total, rsp_if.miss_total);
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic push_req(req_type_t kind, logic [ADDR_BITS-1:0] addr);
        cache_req_t item;
        item.kind = kind;
        item.addr = addr;
        access_q.push_back(item);
        if (kind == REQ_ACCESS)
        begin
            addr_history.push_back(addr);
            if (addr_history.size() > HISTORY_MAX)
                void'(addr_history.pop_front());
        end
    endtask

    task automatic queue_traffic(int count);
        int r;
        int depth;
        logic [ADDR_BITS-1:0] a;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            depth = addr_history.size();
            a = ADDR_BITS'($urandom);
            if (r < 4)
            begin
                push_req(REQ_CLEAR, a);
            end
            else if (r < 40 && depth > 0)
            begin
                push_req(REQ_ACCESS,
                         addr_history[depth - 1 - $urandom_range(depth > 16 ? 15 : depth - 1)]);
            end
            else if (r < 55 && depth > 0)
            begin
                push_req(REQ_ACCESS, addr_history[$urandom_range(depth - 1)]);
            end
            else if (r < 70 && depth > 0)
            begin
                push_req(REQ_ACCESS,
                         ADDR_BITS'(addr_history[depth - 1] + $urandom_range(255)));
            end
            else
            begin
                push_req(REQ_ACCESS, a);
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (access_q.size() != 0 || req_if.valid || tally_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_line_shift(logic [LINE_SHIFT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shift_shadow = value;
    endtask

    task automatic run_phase(logic [LINE_SHIFT_W-1:0] shift, int src_pct, int snk_pct,
                             int count);
        write_line_shift(shift);
        @(negedge clk);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        queue_traffic(count);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_ACCESS;
        req_if.addr = '0;
        rsp_if.ready = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        error_count = 0;
        cycle_count = 0;
        hit_tally = '0;
        miss_tally = '0;
        shift_shadow = LINE_SHIFT_RESET;
        for (int k = 0; k < NUM_LINES; k++)
        begin
            model_tag[k] = '0;
            model_valid[k] = 0;
            model_rank[k] = k;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        push_req(REQ_ACCESS, 31'h0000_0000);
        push_req(REQ_ACCESS, 31'h0000_007F);
        push_req(REQ_ACCESS, 31'h0000_0080);
        push_req(REQ_ACCESS, 31'h7FFF_FFFF);
        push_req(REQ_ACCESS, 31'h7FFF_FF80);
        push_req(REQ_CLEAR, 31'h7FFF_FFFF);
        push_req(REQ_ACCESS, 31'h0000_0001);
        push_req(REQ_ACCESS, 31'h2AAA_AAAA);
        push_req(REQ_ACCESS, 31'h5555_5555);
        push_req(REQ_CLEAR, 31'h0000_0000);
        push_req(REQ_CLEAR, 31'h2AAA_AAAA);
        push_req(REQ_ACCESS, 31'h4000_0000);
        push_req(REQ_ACCESS, 31'h2AAA_AA80);
        push_req(REQ_ACCESS, 31'h0000_00FF);
        push_req(REQ_ACCESS, 31'h0000_0000);
        push_req(REQ_ACCESS, 31'h4000_007F);
        drain();

        run_phase(5'd0, 0, 0, 300);
        run_phase(5'd16, 64, 0, 220);
        run_phase(5'd31, 0, 64, 80);
        run_phase(5'd12, 17, 17, 220);
        run_phase(5'd3, 0, 0, 160);
        run_phase(LINE_SHIFT_W'($urandom_range(31)), 0, 64, 150);

        repeat (NUM_LINES + 16) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
